// File: hw/rtl/pom_pkg.sv
// shared constants and codes for the polyphonic oscillator mixer
package pom_pkg;

  localparam int VOICE_COUNT     = 16;
  localparam int SINE_INDEX_BITS = 10;

  localparam int VIDX_W = $clog2(VOICE_COUNT);
  localparam int CNT_W  = $clog2(VOICE_COUNT + 1);
  // per-voice product is below 2^31 in magnitude
  localparam int SUM_W  = 32 + CNT_W;
  // divisor is active count times 2^29
  localparam int DEN_W  = CNT_W + 29;
  localparam int QUO_W  = 11;
  localparam int QIDX_W = $clog2(QUO_W);
  localparam int REM_W  = DEN_W + QUO_W;

  localparam int OPND_W = 18;
  localparam int PROD_W = 2 * OPND_W;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  localparam logic [2:0] WAVE_SINE   = 3'd0;
  localparam logic [2:0] WAVE_SQUARE = 3'd1;
  localparam logic [2:0] WAVE_TRI    = 3'd2;
  localparam logic [2:0] WAVE_SAW    = 3'd3;

  localparam logic [11:0] DAC_MID = 12'd2048;
  localparam logic [11:0] DAC_TOP = 12'd4095;
  localparam logic [11:0] DAC_BOT = 12'd1;

  // sine polynomial coefficients, q14
  localparam int SIN_C1 = 1160;
  localparam int SIN_C2 = 10512;
  localparam int SIN_C3 = 25736;

endpackage

// File: hw/rtl/polyphonic_oscillator_mixer_unit.sv
// polyphonic oscillator mixer: voice bank, serial mixer and output divider
//
// Sixteen DDS voices (sine, square, triangle, saw) mixed into a 12-bit DAC code.
// One word is worked on at a time; in_stall is high from the accept until the
// result is loaded into the output register. A start or stop word goes straight
// to the hand-over. A tick word walks the voices through one shared 18x18
// multiplier: an idle voice is only scanned; an active triangle, saw or silent
// voice passes scan, gain and accumulate; an active sine or square voice also
// passes square, three polynomial terms and sign (four polynomial products
// plus the gain product). Then come the clamp, the bit-per-cycle divider for
// the 11-bit quotient, the rounding and the hand-over of the result. An empty
// bank or a clamped mix skips the divider and the rounding. The hand-over
// waits while out_stall holds the previous result. A result waiting on
// out_stall does not block the next word from being accepted.
module polyphonic_oscillator_mixer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [31:0] tune_word,
  input  logic [15:0] gain,
  input  logic [2:0]  wave_kind,
  input  logic [3:0]  voice_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] dac_value,
  output logic [3:0]  voice_given,
  output logic        status,
  output logic [4:0]  voices_on
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SQ, S_T1, S_T2, S_T3, S_SGN, S_GAIN, S_ACC,
    S_CLAMP, S_DIV, S_ROUND, S_FINISH
  } state_t;

  state_t state;

  // voice bank
  logic [pom_pkg::VOICE_COUNT-1:0] voice_on;
  logic [31:0] voice_phase [pom_pkg::VOICE_COUNT];
  logic [31:0] voice_step  [pom_pkg::VOICE_COUNT];
  logic [15:0] voice_gain  [pom_pkg::VOICE_COUNT];
  logic [2:0]  voice_wave  [pom_pkg::VOICE_COUNT];

  logic [pom_pkg::CNT_W-1:0]  cnt;
  logic [pom_pkg::VIDX_W-1:0] idx;

  // working registers of the walk
  logic [2:0]                            kind;
  logic [1:0]                            quad;
  logic [14:0]                           u;
  logic [14:0]                           u2;
  logic signed [15:0]                    wave;
  logic [15:0]                           vgain;
  logic signed [pom_pkg::PROD_W-1:0]     prod;
  logic signed [pom_pkg::SUM_W-1:0]      sum;

  // divider
  logic                                  neg;
  logic [pom_pkg::REM_W-1:0]             rem;
  logic [pom_pkg::REM_W-1:0]             dsr;
  logic [pom_pkg::QUO_W-1:0]             quo;
  logic [pom_pkg::QIDX_W-1:0]            qbit;

  // result waiting for the output register
  logic [11:0]                res_dac;
  logic [pom_pkg::VIDX_W-1:0] res_given;
  logic                       res_status;

  // combinational helpers
  logic                       free_found;
  logic [pom_pkg::VIDX_W-1:0] free_idx;
  logic                       in_take;
  logic                       last_voice;
  logic [31:0]                cur_phase;
  logic [15:0]                pos;
  logic [13:0]                frac;
  logic [14:0]                u_next;
  logic [15:0]                p16;
  logic signed [15:0]         wave_direct;
  logic [15:0]                prod_q;
  logic signed [pom_pkg::OPND_W-1:0] mul_a;
  logic signed [pom_pkg::OPND_W-1:0] mul_b;
  logic signed [pom_pkg::PROD_W-1:0] mul_p;
  logic [pom_pkg::DEN_W-1:0]  den;
  logic signed [pom_pkg::SUM_W-1:0] den_s;
  logic [pom_pkg::SUM_W-1:0]  sum_abs;
  logic [pom_pkg::DEN_W-1:0]  abs_d;
  logic signed [12:0]         qs;
  logic [12:0]                dac_full;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  // lowest inactive voice
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = pom_pkg::VOICE_COUNT - 1; i >= 0; i--) begin
      if (!voice_on[i]) begin
        free_found = 1'b1;
        free_idx   = pom_pkg::VIDX_W'(i);
      end
    end
  end

  assign last_voice = (idx == pom_pkg::VIDX_W'(pom_pkg::VOICE_COUNT - 1));

  // waveform front end from the current voice's phase
  assign cur_phase = voice_phase[idx];
  assign pos  = {cur_phase[31 -: pom_pkg::SINE_INDEX_BITS],
                 {(16 - pom_pkg::SINE_INDEX_BITS){1'b0}}};
  assign frac = pos[13:0];
  assign u_next = pos[14] ? (15'd16384 - {1'b0, frac}) : {1'b0, frac};
  assign p16  = cur_phase[31:16];

  always_comb begin
    unique case (voice_wave[idx])
      pom_pkg::WAVE_TRI: begin
        if (!p16[15]) wave_direct = $signed(p16 - 16'd16384);
        else          wave_direct = $signed(16'd49152 - p16);
      end
      pom_pkg::WAVE_SAW: wave_direct = $signed({1'b0, p16[15:1]} - 16'd16384);
      default:           wave_direct = '0;
    endcase
  end

  // shared multiplier
  assign prod_q = prod[14 +: 16];

  always_comb begin
    unique case (state)
      S_SQ: begin
        mul_a = $signed({3'b0, u});
        mul_b = $signed({3'b0, u});
      end
      S_T1: begin
        mul_a = $signed({2'b0, prod_q});
        mul_b = pom_pkg::OPND_W'(pom_pkg::SIN_C1);
      end
      S_T2: begin
        mul_a = $signed({3'b0, u2});
        mul_b = $signed(pom_pkg::OPND_W'(pom_pkg::SIN_C2) - {2'b0, prod_q});
      end
      S_T3: begin
        mul_a = $signed({3'b0, u});
        mul_b = $signed(pom_pkg::OPND_W'(pom_pkg::SIN_C3) - {2'b0, prod_q});
      end
      S_GAIN: begin
        mul_a = pom_pkg::OPND_W'(wave);
        mul_b = $signed({2'b0, vgain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // clamp and divider front end
  assign den     = pom_pkg::DEN_W'(cnt) << 29;
  assign den_s   = $signed(pom_pkg::SUM_W'(den));
  assign sum_abs = sum[pom_pkg::SUM_W-1] ? pom_pkg::SUM_W'(-sum) : pom_pkg::SUM_W'(sum);
  assign abs_d   = sum_abs[pom_pkg::DEN_W-1:0];

  // floor of the signed quotient
  always_comb begin
    if (neg) qs = -$signed({2'b0, quo}) - $signed({12'd0, (rem != '0)});
    else     qs = $signed({2'b0, quo});
    dac_full = 13'(pom_pkg::DAC_MID) + 13'(qs);
  end

  // voice bank payload
  always_ff @(posedge clk) begin
    if (in_take && cmd == pom_pkg::CMD_START && free_found) begin
      voice_phase[free_idx] <= '0;
      voice_step[free_idx]  <= tune_word;
      voice_gain[free_idx]  <= gain;
      voice_wave[free_idx]  <= wave_kind;
    end else if (state == S_SCAN && voice_on[idx]) begin
      voice_phase[idx] <= cur_phase + voice_step[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      voice_on  <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FINISH) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            res_dac    <= pom_pkg::DAC_MID;
            res_given  <= '0;
            res_status <= 1'b0;
            unique case (cmd)
              pom_pkg::CMD_TICK: begin
                sum   <= '0;
                idx   <= '0;
                state <= S_SCAN;
              end
              pom_pkg::CMD_START: begin
                if (free_found) begin
                  voice_on[free_idx] <= 1'b1;
                  cnt                <= cnt + 1'b1;
                  res_given          <= free_idx;
                end else begin
                  res_status <= 1'b1;
                end
                state <= S_FINISH;
              end
              pom_pkg::CMD_STOP: begin
                if (32'(voice_number) < pom_pkg::VOICE_COUNT && voice_on[voice_number]) begin
                  voice_on[voice_number] <= 1'b0;
                  cnt                    <= cnt - 1'b1;
                end
                state <= S_FINISH;
              end
              default: state <= S_FINISH;
            endcase
          end
        end

        S_SCAN: begin
          if (voice_on[idx]) begin
            kind  <= voice_wave[idx];
            vgain <= voice_gain[idx];
            quad  <= pos[15:14];
            u     <= u_next;
            wave  <= wave_direct;
            if (voice_wave[idx] == pom_pkg::WAVE_SINE ||
                voice_wave[idx] == pom_pkg::WAVE_SQUARE) begin
              state <= S_SQ;
            end else begin
              state <= S_GAIN;
            end
          end else if (last_voice) begin
            state <= S_CLAMP;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_SQ: begin
          prod  <= mul_p;
          state <= S_T1;
        end

        S_T1: begin
          u2    <= prod_q[14:0];
          prod  <= mul_p;
          state <= S_T2;
        end

        S_T2: begin
          prod  <= mul_p;
          state <= S_T3;
        end

        S_T3: begin
          prod  <= mul_p;
          state <= S_SGN;
        end

        S_SGN: begin
          if (kind == pom_pkg::WAVE_SINE) begin
            wave <= quad[1] ? -$signed(prod_q) : $signed(prod_q);
          end else if (prod_q != '0 && !quad[1]) begin
            wave <= 16'sd16384;
          end else begin
            wave <= -16'sd16384;
          end
          state <= S_GAIN;
        end

        S_GAIN: begin
          prod  <= mul_p;
          state <= S_ACC;
        end

        S_ACC: begin
          sum <= sum + pom_pkg::SUM_W'(prod);
          if (last_voice) begin
            state <= S_CLAMP;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SCAN;
          end
        end

        S_CLAMP: begin
          priority if (cnt == '0) begin
            state <= S_FINISH;
          end else if (sum >= den_s) begin
            res_dac <= pom_pkg::DAC_TOP;
            state   <= S_FINISH;
          end else if (sum <= -den_s) begin
            res_dac <= pom_pkg::DAC_BOT;
            state   <= S_FINISH;
          end else begin
            // |sum| * 2047 as a shift and subtract
            neg   <= sum[pom_pkg::SUM_W-1];
            rem   <= (pom_pkg::REM_W'(abs_d) << 11) - pom_pkg::REM_W'(abs_d);
            dsr   <= pom_pkg::REM_W'(den) << (pom_pkg::QUO_W - 1);
            quo   <= '0;
            qbit  <= pom_pkg::QIDX_W'(pom_pkg::QUO_W - 1);
            state <= S_DIV;
          end
        end

        S_DIV: begin
          if (rem >= dsr) begin
            rem       <= rem - dsr;
            quo[qbit] <= 1'b1;
          end
          dsr <= dsr >> 1;
          if (qbit == '0) state <= S_ROUND;
          else            qbit  <= qbit - 1'b1;
        end

        S_ROUND: begin
          res_dac <= dac_full[11:0];
          state   <= S_FINISH;
        end

        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            dac_value   <= res_dac;
            voice_given <= res_given;
            status      <= res_status;
            voices_on   <= cnt;
            state       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // active count tracks the voice flags
  assert property (@(posedge clk) disable iff (rst) 32'(cnt) == $countones(voice_on))
    else $error("active count out of step with voice flags");

  // an accepted word blocks the input until its result is handed over
  assert property (@(posedge clk) disable iff (rst) in_valid && !in_stall |=> in_stall)
    else $error("input not held off after accept");

  // a failed start reports a full bank and leaves the code at midscale
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status |->
      voice_given == '0 && dac_value == pom_pkg::DAC_MID &&
      32'(voices_on) == pom_pkg::VOICE_COUNT)
    else $error("no-free status with inconsistent result");

endmodule

// File: tb/polyphonic_oscillator_mixer_unit_tb.sv
// self-checking testbench for the polyphonic oscillator mixer: voice bank, mix and dac codes
module polyphonic_oscillator_mixer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] tune;
    logic [15:0] gain;
    logic [2:0]  wave;
    logic [3:0]  voice;
  } osc_word_t;

  typedef struct {
    logic [11:0] dac;
    logic [3:0]  given;
    logic        status;
    logic [4:0]  on_count;
  } mix_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = pom_pkg::CMD_TICK;
  logic [31:0] tune_word = '0;
  logic [15:0] gain = '0;
  logic [2:0]  wave_kind = pom_pkg::WAVE_SINE;
  logic [3:0]  voice_number = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] dac_value;
  logic [3:0]  voice_given;
  logic        status;
  logic [4:0]  voices_on;

  // predictor copy of the voice bank
  bit [pom_pkg::VOICE_COUNT-1:0] osc_on = '0;
  logic [31:0] osc_phase [pom_pkg::VOICE_COUNT];
  logic [31:0] osc_step [pom_pkg::VOICE_COUNT];
  logic [15:0] osc_gain [pom_pkg::VOICE_COUNT];
  logic [2:0]  osc_wave [pom_pkg::VOICE_COUNT];

  osc_word_t   pending_words [$];
  mix_result_t expected_mix [$];
  osc_word_t   driven_word;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int tick_count = 0;
  int start_count = 0;
  int refused_count = 0;
  int stop_count = 0;
  int clamp_count = 0;
  int peak_voices = 0;

  polyphonic_oscillator_mixer_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .tune_word(tune_word), .gain(gain), .wave_kind(wave_kind),
    .voice_number(voice_number),
    .out_valid(out_valid), .out_stall(out_stall),
    .dac_value(dac_value), .voice_given(voice_given), .status(status),
    .voices_on(voices_on)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // q14 sine from the top phase bits, quarter-wave polynomial
  function automatic longint sine_level(logic [31:0] p);
    longint pos, quad, f, u, u2, inner, mid, s;
    pos = (longint'(p >> (32 - pom_pkg::SINE_INDEX_BITS))
           << (16 - pom_pkg::SINE_INDEX_BITS)) & 'hFFFF;
    quad = pos >> 14;
    f = pos & 16383;
    u = (quad & 1) ? 16384 - f : f;
    u2 = (u * u) >> 14;
    inner = pom_pkg::SIN_C2 - ((u2 * pom_pkg::SIN_C1) >> 14);
    mid = pom_pkg::SIN_C3 - ((u2 * inner) >> 14);
    s = (u * mid) >> 14;
    return (quad & 2) ? -s : s;
  endfunction

  function automatic longint wave_level(logic [2:0] kind, logic [31:0] p);
    longint p16;
    p16 = longint'(p >> 16);
    case (kind)
      pom_pkg::WAVE_SINE:   return sine_level(p);
      pom_pkg::WAVE_SQUARE: return (sine_level(p) > 0) ? 16384 : -16384;
      pom_pkg::WAVE_TRI:    return (p16 < 32768) ? p16 - 16384 : 49152 - p16;
      pom_pkg::WAVE_SAW:    return (p16 >> 1) - 16384;
      default:              return 0;
    endcase
  endfunction

  task automatic predict_word(input osc_word_t w);
    mix_result_t r;
    longint total, den, num, quo;
    int n;
    bit found;
    r.dac = pom_pkg::DAC_MID;
    r.given = '0;
    r.status = 1'b0;
    case (w.cmd)
      pom_pkg::CMD_TICK: begin
        total = 0;
        n = 0;
        tick_count++;
        for (int i = 0; i < pom_pkg::VOICE_COUNT; i++) begin
          if (osc_on[i]) begin
            total += wave_level(osc_wave[i], osc_phase[i]) * longint'(osc_gain[i]);
            n++;
            osc_phase[i] = osc_phase[i] + osc_step[i];
          end
        end
        if (n > 0) begin
          den = longint'(n) << 29;
          if (total >= den) begin
            r.dac = pom_pkg::DAC_TOP;
            clamp_count++;
          end else if (total <= -den) begin
            r.dac = pom_pkg::DAC_BOT;
            clamp_count++;
          end else begin
            num = total * 2047;
            quo = num / den;
            // round toward minus infinity
            if (num % den != 0 && num < 0) quo--;
            r.dac = 12'(2048 + quo);
          end
        end
      end
      pom_pkg::CMD_START: begin
        found = 1'b0;
        start_count++;
        for (int i = 0; i < pom_pkg::VOICE_COUNT; i++) begin
          if (!found && !osc_on[i]) begin
            found = 1'b1;
            osc_on[i] = 1'b1;
            osc_phase[i] = '0;
            osc_step[i] = w.tune;
            osc_gain[i] = w.gain;
            osc_wave[i] = w.wave;
            r.given = 4'(i);
          end
        end
        if (!found) begin
          r.status = 1'b1;
          refused_count++;
        end
      end
      pom_pkg::CMD_STOP: begin
        stop_count++;
        if (int'(w.voice) < pom_pkg::VOICE_COUNT) osc_on[w.voice] = 1'b0;
      end
      default: ;
    endcase
    r.on_count = 5'($countones(osc_on));
    if ($countones(osc_on) > peak_voices) peak_voices = $countones(osc_on);
    expected_mix.push_back(r);
  endtask

  function automatic osc_word_t make_word(logic [1:0] c, logic [31:0] t, logic [15:0] g,
                                          logic [2:0] k, logic [3:0] v);
    osc_word_t w;
    w.cmd = c;
    w.tune = t;
    w.gain = g;
    w.wave = k;
    w.voice = v;
    return w;
  endfunction

  function automatic logic [31:0] pick_tune();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'((longint'($urandom_range(20, 20000)) << 32) / 44100);
      2: return $urandom_range(0, 'hFFFF);
      default: begin
        case ($urandom_range(3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          default: return 32'h4000_0000;
        endcase
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(9))
      0: return 16'd32768;
      1: return 16'd0;
      2, 3: return 16'($urandom_range(32769, 65535));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  // random words in runs of 32, each run leaning toward filling or draining the bank
  task automatic push_random(input int count);
    int start_pct, r;
    osc_word_t w;
    start_pct = 25;
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) begin
        case ($urandom_range(2))
          0: start_pct = 8;
          1: start_pct = 25;
          default: start_pct = 45;
        endcase
      end
      r = $urandom_range(99);
      w = make_word(pom_pkg::CMD_TICK, $urandom, 16'($urandom), 3'($urandom),
                    4'($urandom));
      if (r < start_pct) begin
        w.cmd = pom_pkg::CMD_START;
        w.tune = pick_tune();
        w.gain = pick_gain();
        w.wave = ($urandom_range(4) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
      end else if (r < start_pct + 15) begin
        w.cmd = pom_pkg::CMD_STOP;
      end else if (r < start_pct + 18) begin
        w.cmd = CMD_UNUSED;
      end
      pending_words.push_back(w);
    end
  endtask

  task automatic wait_drain();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_mix.size() != 0);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int count);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    push_random(count);
    wait_drain();
  endtask

  // driver
  always @(posedge clk) begin : drive_words
    osc_word_t nxt;
    if (!rst) begin
      if (in_valid && !in_stall) predict_word(driven_word);
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_words.pop_front();
          driven_word = nxt;
          cmd <= nxt.cmd;
          tune_word <= nxt.tune;
          gain <= nxt.gain;
          wave_kind <= nxt.wave;
          voice_number <= nxt.voice;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin : check_results
    mix_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_mix.size() == 0) begin
          $error("result word with nothing expected: dac_value %0d voice_given %0d",
                 dac_value, voice_given);
          fail_count++;
        end else begin
          want = expected_mix.pop_front();
          if (dac_value !== want.dac) begin
            $error("dac_value: expected %0d, got %0d", want.dac, dac_value);
            fail_count++;
          end
          if (voice_given !== want.given) begin
            $error("voice_given: expected %0d, got %0d", want.given, voice_given);
            fail_count++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_count++;
          end
          if (voices_on !== want.on_count) begin
            $error("voices_on: expected %0d, got %0d", want.on_count, voices_on);
            fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("polyphonic_oscillator_mixer_unit: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty bank, unused code, stop of an idle voice
    pending_words.push_back(make_word(pom_pkg::CMD_TICK, '0, '0, pom_pkg::WAVE_SINE, '0));
    pending_words.push_back(make_word(CMD_UNUSED, '1, '1, 3'd7, '1));
    pending_words.push_back(make_word(pom_pkg::CMD_STOP, '0, '0, pom_pkg::WAVE_SINE, 4'd9));
    // quarter-cycle sine at full gain walks all four quadrants, hitting both clamps
    pending_words.push_back(make_word(pom_pkg::CMD_START, 32'h4000_0000, 16'd32768,
                                      pom_pkg::WAVE_SINE, '0));
    repeat (4)
      pending_words.push_back(make_word(pom_pkg::CMD_TICK, '0, '0, pom_pkg::WAVE_SINE, '0));
    pending_words.push_back(make_word(pom_pkg::CMD_START, 32'hFFFF_FFFF, 16'hFFFF,
                                      pom_pkg::WAVE_SQUARE, '0));
    pending_words.push_back(make_word(pom_pkg::CMD_START, 32'h8000_0000, 16'd32768,
                                      pom_pkg::WAVE_TRI, '0));
    pending_words.push_back(make_word(pom_pkg::CMD_START, 32'h0000_0001, 16'd0,
                                      pom_pkg::WAVE_SAW, '0));
    pending_words.push_back(make_word(pom_pkg::CMD_START, $urandom, 16'd32768, 3'd4, '0));
    pending_words.push_back(make_word(pom_pkg::CMD_START, $urandom, 16'hFFFF, 3'd7, '0));
    pending_words.push_back(make_word(pom_pkg::CMD_TICK, '0, '0, pom_pkg::WAVE_SINE, '0));
    // fill the bank, the last start is refused
    for (int i = 0; i < 11; i++)
      pending_words.push_back(make_word(pom_pkg::CMD_START, pick_tune(), pick_gain(),
                                        3'(i % 4), '0));
    pending_words.push_back(make_word(pom_pkg::CMD_TICK, '0, '0, pom_pkg::WAVE_SINE, '0));
    pending_words.push_back(make_word(pom_pkg::CMD_STOP, '0, '0, pom_pkg::WAVE_SINE, 4'd15));
    pending_words.push_back(make_word(pom_pkg::CMD_STOP, '0, '0, pom_pkg::WAVE_SINE, 4'd0));

    run_phase(0, 0, 356);
    run_phase(79, 0, 356);
    run_phase(0, 79, 356);
    run_phase(25, 25, 356);

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_mix.size() != 0) begin
      $error("%0d expected result words never arrived", expected_mix.size());
      fail_count++;
    end

    $display("covered %0d ticks (%0d clamped), %0d starts (%0d refused), %0d stops",
             tick_count, clamp_count, start_count, refused_count, stop_count);
    $display("peak of %0d voices active, %0d cycles, %0d failures",
             peak_voices, cycle_count, fail_count);
    if (fail_count == 0) begin
      $display("polyphonic_oscillator_mixer_unit: match");
    end else begin
      $display("polyphonic_oscillator_mixer_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/pom_pkg.sv
hw/rtl/polyphonic_oscillator_mixer_unit.sv
tb/polyphonic_oscillator_mixer_unit_tb.sv
